// ----- sv/tso_store_buffer_core_defines.svh -----
// Assertion macros for the TSO store buffer core.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef TSO_STORE_BUFFER_CORE_DEFINES_SVH
`define TSO_STORE_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSOSB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TSOSB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tsosb_pkg.sv -----
// Shared types and constants for the TSO store buffer core.
// Used by tsosb_fifo, tsosb_dmem and tso_store_buffer_core; depends on nothing.
package tsosb_pkg;

  localparam int AddrW    = 8;
  localparam int RegIdxW  = 3;
  localparam int DataW    = 32;
  localparam int NumRegs  = 6;
  localparam int AddrSpan = 2 ** AddrW;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STORE = 2'd1,
    OP_SET   = 2'd2,
    OP_DRAIN = 2'd3
  } op_e;

  localparam logic KIND_MEM = 1'b0;
  localparam logic KIND_REG = 1'b1;

  typedef struct packed {
    op_e                      op;
    logic [RegIdxW-1:0]       reg_index;
    logic [AddrW-1:0]         address;
    logic signed [DataW-1:0]  immediate;
  } in_item_t;

  typedef struct packed {
    logic                     kind;
    logic [AddrW-1:0]         out_address;
    logic [RegIdxW-1:0]       out_reg;
    logic signed [DataW-1:0]  value;
    logic                     last;
  } out_item_t;

  // One queued store: the address as issued and the source register.
  typedef struct packed {
    logic [AddrW-1:0]   address;
    logic [RegIdxW-1:0] reg_index;
  } buf_entry_t;

  // One data memory word with its store-pending flag.
  typedef struct packed {
    logic             pending;
    logic [DataW-1:0] data;
  } mem_word_t;

  typedef struct packed {
    logic push;
    logic drain_start;
    logic drain_next;
    logic drain_done;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic head_final;
  } fifo_sts_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_REREAD,
    ST_DRAIN_RD,
    ST_DRAIN_WR,
    ST_WRITEBACK
  } state_e;

endpackage

// ----- sv/tso_store_buffer_core.sv -----
// One core under total store order: six registers, a FIFO store buffer and a data memory.
// Top level; depends on tsosb_pkg, tsosb_fifo, tsosb_dmem and the assertion macro header.
//
// After reset the block clears its data memory and holds in_stall_o high during the
// sweep and until its state machine has reached the idle state. Each item then goes
// through its own sequence of steps, paced by the registered reads of the data memory
// and the store buffer memory. A store that finds room is accepted and then does a
// read-modify-write of its word's pending flag; a drain of an empty buffer and an item
// that names a register that does not exist are accepted and checked and end there. A
// load or an immediate assignment without a hazard is accepted, checked and written
// back to its register. A drain of N queued stores is accepted and checked, reads the
// oldest entry, then retires one stored word per cycle from the buffer memory while the
// output register can take a result; a load, assignment or full store that must drain
// first runs the read of the oldest entry, the N retirements and a reread of its own
// memory word before the check runs again. Results wait in one output register, so a stall
// on the result side holds the block only while a new result would replace one still held.

`include "tso_store_buffer_core_defines.svh"

module tso_store_buffer_core #(
  parameter int BUFFER_DEPTH = 8,
  parameter int MEMORY_WORDS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tsosb_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tsosb_pkg::out_item_t out_data_o
);

  localparam int MemAw = $clog2(MEMORY_WORDS);

  // Word index of every possible address, the address taken modulo MEMORY_WORDS.
  logic [MemAw-1:0] mod_tbl [tsosb_pkg::AddrSpan];

  for (genvar g = 0; g < tsosb_pkg::AddrSpan; g++) begin : g_mod
    assign mod_tbl[g] = MemAw'(g % MEMORY_WORDS);
  end

  tsosb_pkg::state_e    state_q, state_d;
  tsosb_pkg::in_item_t  item_q;
  logic [MemAw-1:0]     mi_q;
  logic [tsosb_pkg::DataW-1:0] reg_q [tsosb_pkg::NumRegs];
  logic [tsosb_pkg::NumRegs-1:0] reg_pend_q;
  logic                 out_valid_q;
  tsosb_pkg::out_item_t out_q;

  logic                 accept;
  logic                 out_free;
  logic                 reg_ok;
  logic                 hazard;
  logic [tsosb_pkg::DataW-1:0] drain_val;

  logic                 emit;
  tsosb_pkg::out_item_t emit_data;
  logic                 reg_we;
  logic [tsosb_pkg::DataW-1:0] reg_wdata;
  logic                 pend_set;
  logic                 pend_clr_all;

  logic                 dmem_re;
  logic [MemAw-1:0]     dmem_raddr;
  logic                 dmem_we;
  logic [MemAw-1:0]     dmem_waddr;
  tsosb_pkg::mem_word_t dmem_wdata;
  tsosb_pkg::mem_word_t dmem_rdata;
  logic                 dmem_busy;

  tsosb_pkg::fifo_ctl_t  fifo_ctl;
  tsosb_pkg::fifo_sts_t  fifo_sts;
  tsosb_pkg::buf_entry_t fifo_head;
  tsosb_pkg::buf_entry_t push_entry;

  tsosb_fifo #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (fifo_ctl),
    .push_entry_i (push_entry),
    .sts_o        (fifo_sts),
    .head_o       (fifo_head)
  );

  tsosb_dmem #(
    .MEMORY_WORDS (MEMORY_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (dmem_re),
    .raddr_i (dmem_raddr),
    .we_i    (dmem_we),
    .waddr_i (dmem_waddr),
    .wdata_i (dmem_wdata),
    .rdata_o (dmem_rdata),
    .busy_o  (dmem_busy)
  );

  assign in_stall_o = (state_q != tsosb_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == tsosb_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Registers six and seven do not exist; such items are dropped without effect.
  assign reg_ok = (item_q.reg_index < tsosb_pkg::RegIdxW'(tsosb_pkg::NumRegs));

  // A load must drain when its word or register is still owed by a queued store, an assignment
  // when its register is; the word's pending flag comes from the read at accept or reread.
  assign hazard = (item_q.op == tsosb_pkg::OP_LOAD)
                ? (dmem_rdata.pending || reg_pend_q[item_q.reg_index])
                : reg_pend_q[item_q.reg_index];

  // A queued store takes its value from the register file at the time it drains.
  assign drain_val  = reg_q[fifo_head.reg_index];
  assign push_entry = '{address: item_q.address, reg_index: item_q.reg_index};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsosb_pkg::ST_CLEAR: begin
        if (!dmem_busy) begin
          state_d = tsosb_pkg::ST_IDLE;
        end
      end
      tsosb_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tsosb_pkg::ST_DECIDE;
        end
      end
      tsosb_pkg::ST_DECIDE: begin
        if (item_q.op == tsosb_pkg::OP_DRAIN) begin
          state_d = fifo_sts.empty ? tsosb_pkg::ST_IDLE : tsosb_pkg::ST_DRAIN_RD;
        end else if (!reg_ok) begin
          state_d = tsosb_pkg::ST_IDLE;
        end else if (item_q.op == tsosb_pkg::OP_STORE) begin
          state_d = fifo_sts.full ? tsosb_pkg::ST_DRAIN_RD : tsosb_pkg::ST_IDLE;
        end else begin
          state_d = hazard ? tsosb_pkg::ST_DRAIN_RD : tsosb_pkg::ST_WRITEBACK;
        end
      end
      tsosb_pkg::ST_REREAD: begin
        state_d = tsosb_pkg::ST_DECIDE;
      end
      tsosb_pkg::ST_DRAIN_RD: begin
        state_d = tsosb_pkg::ST_DRAIN_WR;
      end
      tsosb_pkg::ST_DRAIN_WR: begin
        if (out_free && fifo_sts.head_final) begin
          // Anything but a drain item reruns its check on the updated memory.
          state_d = (item_q.op == tsosb_pkg::OP_DRAIN) ? tsosb_pkg::ST_IDLE
                                                       : tsosb_pkg::ST_REREAD;
        end
      end
      tsosb_pkg::ST_WRITEBACK: begin
        if (out_free) begin
          state_d = tsosb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsosb_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    emit         = 1'b0;
    emit_data    = '0;
    reg_we       = 1'b0;
    reg_wdata    = dmem_rdata.data;
    pend_set     = 1'b0;
    pend_clr_all = 1'b0;
    dmem_re      = 1'b0;
    dmem_raddr   = mi_q;
    dmem_we      = 1'b0;
    dmem_waddr   = mi_q;
    dmem_wdata   = dmem_rdata;
    fifo_ctl     = '0;
    case (state_q)
      tsosb_pkg::ST_IDLE: begin
        dmem_re    = accept;
        dmem_raddr = mod_tbl[in_data_i.address];
      end
      tsosb_pkg::ST_DECIDE: begin
        if (item_q.op == tsosb_pkg::OP_STORE && reg_ok && !fifo_sts.full) begin
          // Queue the store and mark its word pending, keeping the word's data.
          fifo_ctl.push      = 1'b1;
          pend_set           = 1'b1;
          dmem_we            = 1'b1;
          dmem_wdata.pending = 1'b1;
        end
      end
      tsosb_pkg::ST_REREAD: begin
        dmem_re = 1'b1;
      end
      tsosb_pkg::ST_DRAIN_RD: begin
        fifo_ctl.drain_start = 1'b1;
      end
      tsosb_pkg::ST_DRAIN_WR: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.kind        = tsosb_pkg::KIND_MEM;
          emit_data.out_address = fifo_head.address;
          emit_data.value       = drain_val;
          // Only loads and assignments add a register result after the drain.
          emit_data.last        = fifo_sts.head_final
                                && (item_q.op == tsosb_pkg::OP_STORE
                                 || item_q.op == tsosb_pkg::OP_DRAIN);
          dmem_we               = 1'b1;
          dmem_waddr            = mod_tbl[fifo_head.address];
          dmem_wdata            = '{pending: 1'b0, data: drain_val};
          if (fifo_sts.head_final) begin
            fifo_ctl.drain_done = 1'b1;
            pend_clr_all        = 1'b1;
          end else begin
            fifo_ctl.drain_next = 1'b1;
          end
        end
      end
      tsosb_pkg::ST_WRITEBACK: begin
        if (item_q.op == tsosb_pkg::OP_SET) begin
          reg_wdata = item_q.immediate;
        end
        if (out_free) begin
          emit              = 1'b1;
          reg_we            = 1'b1;
          emit_data.kind    = tsosb_pkg::KIND_REG;
          emit_data.out_reg = item_q.reg_index;
          emit_data.value   = reg_wdata;
          emit_data.last    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsosb_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      mi_q   <= mod_tbl[in_data_i.address];
    end
  end

  // Register file and its pending flags. Every pending register has a store
  // in the buffer, so a full drain clears all flags at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tsosb_pkg::NumRegs; i++) begin
        reg_q[i] <= '0;
      end
      reg_pend_q <= '0;
    end else begin
      if (reg_we) begin
        reg_q[item_q.reg_index] <= reg_wdata;
      end
      if (pend_clr_all) begin
        reg_pend_q <= '0;
      end else if (pend_set) begin
        reg_pend_q[item_q.reg_index] <= 1'b1;
      end
    end
  end

  // Output register: a new result may replace one that is being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TSOSB_ASSERT_IMPL(a_no_push_full, fifo_ctl.push, !fifo_sts.full, "push into full store buffer")
  `TSOSB_ASSERT_IMPL(a_stall_clear, dmem_busy, in_stall_o, "item accepted during memory clear")
  `TSOSB_ASSERT_IMPL(a_reg_wb_clean, reg_we, !reg_pend_q[item_q.reg_index], "register written while a store still owes it")
  `TSOSB_ASSERT_NEXT(a_drain_empties, fifo_ctl.drain_done, fifo_sts.empty, "store buffer not empty after drain")

endmodule

// ----- sv/tsosb_fifo.sv -----
// Store buffer queue: a memory of queued stores with fill count and drain pointer.
// Depends on tsosb_pkg.
module tsosb_fifo #(
  parameter int BUFFER_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsosb_pkg::fifo_ctl_t  ctl_i,
  input  tsosb_pkg::buf_entry_t push_entry_i,
  output tsosb_pkg::fifo_sts_t  sts_o,
  output tsosb_pkg::buf_entry_t head_o
);

  localparam int BufAw = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CntW  = $clog2(BUFFER_DEPTH + 1);

  tsosb_pkg::buf_entry_t mem_q [BUFFER_DEPTH];
  tsosb_pkg::buf_entry_t head_q;
  logic [CntW-1:0]       count_q;
  logic [BufAw-1:0]      rd_idx_q;
  logic [BufAw-1:0]      rd_nxt;

  assign rd_nxt = rd_idx_q + BufAw'(1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[count_q[BufAw-1:0]] <= push_entry_i;
    end
    if (ctl_i.drain_start) begin
      head_q <= mem_q[0];
    end else if (ctl_i.drain_next) begin
      head_q <= mem_q[rd_nxt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
    end else begin
      if (ctl_i.drain_done) begin
        count_q <= '0;
      end else if (ctl_i.push) begin
        count_q <= count_q + CntW'(1);
      end
      if (ctl_i.drain_start) begin
        rd_idx_q <= '0;
      end else if (ctl_i.drain_next) begin
        rd_idx_q <= rd_nxt;
      end
    end
  end

  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q == CntW'(BUFFER_DEPTH));
  assign sts_o.head_final = ((CntW'(rd_idx_q) + CntW'(1)) == count_q);
  assign head_o           = head_q;

endmodule

// ----- sv/tsosb_dmem.sv -----
// Data memory with a pending flag per word and a clearing sweep after reset.
// Depends on tsosb_pkg.
module tsosb_dmem #(
  parameter int MEMORY_WORDS = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  re_i,
  input  logic [$clog2(MEMORY_WORDS)-1:0]       raddr_i,
  input  logic                                  we_i,
  input  logic [$clog2(MEMORY_WORDS)-1:0]       waddr_i,
  input  tsosb_pkg::mem_word_t                  wdata_i,
  output tsosb_pkg::mem_word_t                  rdata_o,
  output logic                                  busy_o
);

  localparam int MemAw = $clog2(MEMORY_WORDS);

  tsosb_pkg::mem_word_t mem_q [MEMORY_WORDS];
  tsosb_pkg::mem_word_t rdata_q;
  logic [MemAw-1:0]     clr_idx_q;
  logic                 busy_q;

  logic                 we;
  logic [MemAw-1:0]     waddr;
  tsosb_pkg::mem_word_t wdata;

  // The sweep owns the write port until every word holds zero.
  assign we    = busy_q | we_i;
  assign waddr = busy_q ? clr_idx_q : waddr_i;
  assign wdata = busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_idx_q <= '0;
    end else if (busy_q) begin
      clr_idx_q <= clr_idx_q + MemAw'(1);
      if (clr_idx_q == MemAw'(MEMORY_WORDS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule
